// ===== design/gzsf_pkg.sv =====
// ----------------------------------------------------------------------------
// gzsf_pkg
// shared widths, register indexes, mode codes and divider constants for the
// gyro z selectable filter
// ----------------------------------------------------------------------------
package gzsf_pkg;

  // raw sample and filtered z widths
  localparam int RATE_W = 16;
  localparam int FRAC_W = 8;
  localparam int Z_W    = RATE_W + FRAC_W;

  // moving average window
  localparam int WINDOW_LENGTH = 10;
  localparam int PTR_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W = RATE_W + 1 + $clog2(WINDOW_LENGTH);

  // divide by WINDOW_LENGTH: magnitude * DIV_MULT >> DIV_SHIFT, exact for
  // any magnitude below 2**DIV_IN_W
  localparam int DIV_IN_W   = SUM_W - 1 + FRAC_W;
  localparam int DIV_SHIFT  = DIV_IN_W + $clog2(WINDOW_LENGTH);
  localparam int DIV_MULT_W = DIV_SHIFT - $clog2(WINDOW_LENGTH) + 1;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_WEIGHT = 1'd1;

  // filter modes, the unused code behaves as pass-through
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOWPASS = 2'd2;

  // low-pass weight, unsigned Q1.8
  localparam int WEIGHT_W = 9;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd64;

  localparam int IN_DATA_W  = 3 * RATE_W;
  localparam int OUT_DATA_W = 2 * RATE_W + Z_W;

endpackage

// ===== design/gyro_z_selectable_filter.sv =====
// ----------------------------------------------------------------------------
// gyro_z_selectable_filter
// three-axis gyro sample stream; x and y pass through, z is widened to eight
// fraction bits and filtered by pass-through, moving average or low-pass
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                beat contents (low bit up)
// s_axis   in         s_tvalid / s_tready      rate_x_raw, rate_y_raw, rate_z_raw
// m_axis   out        m_tvalid / m_tready      rate_x_out, rate_y_out, rate_z_filtered
// cfg      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one beat per cycle sustained while m_tready stays high; a sample is held
// in the input register, then the filter path (ring sum plus reciprocal
// multiply, or the low-pass multiply) writes the output register
// reset (rst, synchronous) clears the ring, sum, pointer, last z output and
// both valid flags, and loads filter_mode 1 and blend_weight 64
// a stall on m_tready holds the output beat; the input register still takes
// one more beat, then s_tready drops until the output drains
// cfg_ready is always high
//
module gyro_z_selectable_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  // rate_x_raw [15:0], rate_y_raw [31:16], rate_z_raw [47:32]
  input  logic [gzsf_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // rate_x_out [15:0], rate_y_out [31:16], rate_z_filtered [55:32]
  output logic [gzsf_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gzsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gzsf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [gzsf_pkg::MODE_W-1:0]   filter_mode;
  logic [gzsf_pkg::WEIGHT_W-1:0] blend_weight;

  // input register
  logic                               in_valid;
  logic signed [gzsf_pkg::RATE_W-1:0] in_x;
  logic signed [gzsf_pkg::RATE_W-1:0] in_y;
  logic signed [gzsf_pkg::RATE_W-1:0] in_z;

  // output register; the z field doubles as the last z output
  logic                               out_valid;
  logic signed [gzsf_pkg::RATE_W-1:0] out_x;
  logic signed [gzsf_pkg::RATE_W-1:0] out_y;
  logic signed [gzsf_pkg::Z_W-1:0]    last_z;

  logic advance;
  logic avg_step;

  logic signed [gzsf_pkg::Z_W-1:0]    z_wide;
  logic signed [gzsf_pkg::Z_W-1:0]    avg_z;
  logic signed [gzsf_pkg::Z_W-1:0]    lp_z;
  logic signed [gzsf_pkg::Z_W-1:0]    z_next;
  logic [gzsf_pkg::WEIGHT_W-1:0]      weight_sat;
  logic signed [gzsf_pkg::Z_W:0]      lp_diff;
  logic signed [gzsf_pkg::Z_W+gzsf_pkg::WEIGHT_W+1:0] lp_prod;
  logic signed [gzsf_pkg::Z_W+gzsf_pkg::WEIGHT_W+1:0] lp_biased;
  logic signed [gzsf_pkg::Z_W:0]      lp_step;

  // pipeline flow: the filter stage moves when the output slot is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign avg_step = advance && (filter_mode == gzsf_pkg::MODE_AVERAGE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= gzsf_pkg::MODE_AVERAGE;
      blend_weight <= gzsf_pkg::WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gzsf_pkg::REG_FILTER_MODE:  filter_mode  <= cfg_data[gzsf_pkg::MODE_W-1:0];
        gzsf_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data[gzsf_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x <= s_tdata[gzsf_pkg::RATE_W-1:0];
      in_y <= s_tdata[2*gzsf_pkg::RATE_W-1:gzsf_pkg::RATE_W];
      in_z <= s_tdata[3*gzsf_pkg::RATE_W-1:2*gzsf_pkg::RATE_W];
    end
  end

  // z in 1/256 of a raw LSB (eight fraction bits)
  assign z_wide = {in_z, {gzsf_pkg::FRAC_W{1'b0}}};

  // moving average ring
  gzsf_average u_average (
    .clk     (clk),
    .rst     (rst),
    .step    (avg_step),
    .sample  (in_z),
    .average (avg_z)
  );

  // low-pass: last + w*(z - last)/256, quotient truncated toward zero
  assign weight_sat = (blend_weight > gzsf_pkg::WEIGHT_ONE) ? gzsf_pkg::WEIGHT_ONE
                                                            : blend_weight;
  assign lp_diff   = (gzsf_pkg::Z_W+1)'(z_wide) - (gzsf_pkg::Z_W+1)'(last_z);
  assign lp_prod   = $signed({1'b0, weight_sat}) * lp_diff;
  assign lp_biased = lp_prod[gzsf_pkg::Z_W+gzsf_pkg::WEIGHT_W+1]
                   ? lp_prod + (gzsf_pkg::Z_W+gzsf_pkg::WEIGHT_W+2)'((1 << gzsf_pkg::FRAC_W) - 1)
                   : lp_prod;
  assign lp_step   = (gzsf_pkg::Z_W+1)'(lp_biased >>> gzsf_pkg::FRAC_W);
  assign lp_z      = gzsf_pkg::Z_W'((gzsf_pkg::Z_W+1)'(last_z) + lp_step);

  // mode select
  always_comb begin
    case (filter_mode)
      gzsf_pkg::MODE_AVERAGE: z_next = avg_z;
      gzsf_pkg::MODE_LOWPASS: z_next = lp_z;
      default:                z_next = z_wide;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_z    <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        last_z    <= z_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x <= in_x;
      out_y <= in_y;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {last_z, out_y, out_x};

  ap_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("valid set right after reset");

  ap_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed beat missing at output");

  ap_pass_frac: assert property (@(posedge clk) disable iff (rst)
    (advance && filter_mode != gzsf_pkg::MODE_AVERAGE
             && filter_mode != gzsf_pkg::MODE_LOWPASS)
    |=> m_tdata[2*gzsf_pkg::RATE_W+gzsf_pkg::FRAC_W-1:2*gzsf_pkg::RATE_W] == '0)
    else $error("pass-through z has fraction bits");

  ap_last_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(last_z))
    else $error("last z output changed without a beat");

endmodule

// ===== design/gzsf_average.sv =====
// ----------------------------------------------------------------------------
// gzsf_average
// moving average ring with running sum and constant reciprocal divide
// ----------------------------------------------------------------------------
module gzsf_average (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic signed [gzsf_pkg::RATE_W-1:0]  sample,
  output logic signed [gzsf_pkg::Z_W-1:0]     average
);

  logic signed [gzsf_pkg::RATE_W-1:0] ring [gzsf_pkg::WINDOW_LENGTH];
  logic [gzsf_pkg::PTR_W-1:0]         ptr;
  logic signed [gzsf_pkg::SUM_W-1:0]  sum;
  logic signed [gzsf_pkg::SUM_W-1:0]  sum_next;
  logic [gzsf_pkg::SUM_W-1:0]         mag;
  logic [gzsf_pkg::DIV_IN_W-1:0]      scaled;
  logic [gzsf_pkg::DIV_IN_W+gzsf_pkg::DIV_MULT_W-1:0] prod;
  logic [gzsf_pkg::Z_W-1:0]           quot;

  // oldest entry leaves, new sample enters
  assign sum_next = sum + gzsf_pkg::SUM_W'(sample) - gzsf_pkg::SUM_W'(ring[ptr]);

  // truncate toward zero: divide the magnitude, then restore the sign
  assign mag    = sum_next[gzsf_pkg::SUM_W-1] ? gzsf_pkg::SUM_W'(-sum_next)
                                              : gzsf_pkg::SUM_W'(sum_next);
  assign scaled = {mag[gzsf_pkg::SUM_W-2:0], {gzsf_pkg::FRAC_W{1'b0}}};
  assign prod   = (gzsf_pkg::DIV_IN_W+gzsf_pkg::DIV_MULT_W)'(scaled)
                * (gzsf_pkg::DIV_IN_W+gzsf_pkg::DIV_MULT_W)'
                    (gzsf_pkg::DIV_MULT_W'(gzsf_pkg::DIV_MULT));
  assign quot   = gzsf_pkg::Z_W'(prod >> gzsf_pkg::DIV_SHIFT);
  assign average = sum_next[gzsf_pkg::SUM_W-1] ? -$signed(quot) : $signed(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gzsf_pkg::WINDOW_LENGTH; i++) begin
        ring[i] <= '0;
      end
      ptr <= '0;
      sum <= '0;
    end else if (step) begin
      ring[ptr] <= sample;
      sum <= sum_next;
      if (ptr == gzsf_pkg::PTR_W'(gzsf_pkg::WINDOW_LENGTH - 1)) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  ap_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= gzsf_pkg::PTR_W'(gzsf_pkg::WINDOW_LENGTH - 1))
    else $error("ring pointer past window");

  ap_sum_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(sum) && $stable(ptr))
    else $error("ring changed without a step");

endmodule
